>>> src/pva_pkg.sv
// Shared types, codes and pitch/level functions for the polyphonic voice allocator.
package pva_pkg;

    localparam logic [7:0] ST_NOTE_ON  = 8'd144;
    localparam logic [7:0] ST_NOTE_OFF = 8'd128;

    localparam logic CMD_SILENCE = 1'b0;
    localparam logic CMD_START   = 1'b1;

    localparam int FREQ_W = 22;
    localparam int AMP_W  = 16;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [6:0]  note_number;
        logic [6:0]  velocity;
        logic [15:0] delta_ticks;
    } t_in;

    typedef struct packed {
        logic              command;
        logic [2:0]        voice_index;
        logic [6:0]        note_out;
        logic [FREQ_W-1:0] frequency_q8;
        logic [AMP_W-1:0]  amplitude_q15;
        logic [2:0]        busy_count;
        logic              last;
    } t_out;

    typedef struct packed {
        logic latch;
        logic scan_start;
        logic scan_run;
        logic emit_kill;
        logic emit_free;
        logic emit_start;
    } t_cmd;

    typedef struct packed {
        logic is_on;
        logic is_off;
        logic stack_empty;
        logic scan_done;
        logic found;
        logic out_free;
    } t_sts;

    function automatic logic [FREQ_W-1:0] top_octave(input logic [3:0] slot);
        logic [FREQ_W-1:0] f;
        unique case (slot)
            4'd0:    f = 22'd1701088;
            4'd1:    f = 22'd1802240;
            4'd2:    f = 22'd1909406;
            4'd3:    f = 22'd2022946;
            4'd4:    f = 22'd2143236;
            4'd5:    f = 22'd2270680;
            4'd6:    f = 22'd2405701;
            4'd7:    f = 22'd2548752;
            4'd8:    f = 22'd2700308;
            4'd9:    f = 22'd2860877;
            4'd10:   f = 22'd3030994;
            4'd11:   f = 22'd3211226;
            default: f = '0;
        endcase
        return f;
    endfunction

    // octave = (note+4)/12 by reciprocal 171/2048, exact for values up to 131
    function automatic logic [FREQ_W-1:0] freq_q8(input logic [6:0] note);
        logic [7:0]  n4;
        logic [15:0] prod;
        logic [3:0]  oct;
        logic [7:0]  slot8;
        logic [3:0]  shamt;
        n4    = {1'b0, note} + 8'd4;
        prod  = 16'(n4) * 16'd171;
        oct   = prod[14:11];
        slot8 = n4 - {1'b0, oct, 3'b000} - {2'b00, oct, 2'b00};
        shamt = 4'd10 - oct;
        return top_octave(slot8[3:0]) >> shamt;
    endfunction

    // velocity*16384/63 = velocity*260 + floor(4*velocity/63)
    function automatic logic [AMP_W-1:0] amp_q15(input logic [6:0] vel);
        logic [15:0] base;
        logic [15:0] prod;
        base = 16'(vel) * 16'd260;
        prod = (16'({vel, 2'b00}) + 16'd1) * 16'd65;
        return base + (prod >> 12);
    endfunction

endpackage

>>> src/pva_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pva_ctrl.sv
// Event sequencer of the voice allocator: accept, scan, steal, free and start.
module pva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pva_pkg::t_sts i_sts,
    output pva_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD_SCAN,
        S_KILL,
        S_POP,
        S_START,
        S_OFF_SCAN,
        S_FREE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    if (i_sts.is_on) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = i_sts.stack_empty ? S_OLD_SCAN : S_POP;
                    end else if (i_sts.is_off) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_OFF_SCAN;
                    end
                end
            end
            S_OLD_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_KILL;
                end
            end
            S_KILL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_kill = 1'b1;
                    n_state = S_START;
                end
            end
            S_POP: begin
                n_state = S_START;
            end
            S_START: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OFF_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.found ? S_FREE : S_IDLE;
                end
            end
            S_FREE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_free = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/pva_dp.sv
// Voice tables, free stack, voice scan and result register of the voice allocator.
module pva_dp #(
    parameter int VOICES    = 5,
    parameter int TIME_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pva_pkg::t_in  i_in_data,
    input  pva_pkg::t_cmd i_cmd,
    output pva_pkg::t_sts o_sts,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output pva_pkg::t_out o_out_data
);

    localparam int VW = $clog2(VOICES);
    localparam int CW = VW + 1;
    localparam logic [CW-1:0] NV       = CW'(VOICES);
    localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);

    logic [6:0]           r_note;
    logic [6:0]           r_vel;
    logic [TIME_BITS-1:0] r_time;
    logic [VOICES-1:0]    r_valid;
    logic [VOICES-1:0]    r_stk_wr;
    logic [CW-1:0]        r_depth;
    logic [CW-1:0]        r_busy;
    logic [CW-1:0]        r_scan_addr;
    logic                 r_cmp_vld;
    logic [VW-1:0]        r_cmp_idx;
    logic [TIME_BITS-1:0] r_min;
    logic [VW-1:0]        r_old;
    logic                 r_found;
    logic [VW-1:0]        r_hit;
    logic                 r_steal;
    logic                 r_out_vld;
    pva_pkg::t_out        r_out;

    logic [CW-1:0]        n_busy;
    logic [CW-1:0]        n_depth;
    pva_pkg::t_out        n_out;

    logic [6:0]           note_rdata;
    logic [TIME_BITS-1:0] start_rdata;
    logic [VW-1:0]        stk_rdata;
    logic [VW-1:0]        stk_ridx;
    logic [VW-1:0]        popped;
    logic [VW-1:0]        start_voice;
    logic                 scan_issue;
    logic                 note_hit;
    logic                 older;
    logic                 push;
    logic                 emit;
    logic                 out_free;

    assign scan_issue  = i_cmd.scan_run && (r_scan_addr < NV);
    assign stk_ridx    = VW'(r_depth - CW'(1));
    assign popped      = r_stk_wr[stk_ridx] ? stk_rdata : (LAST_IDX - stk_ridx);
    assign start_voice = r_steal ? r_old : popped;
    assign note_hit    = r_cmp_vld && r_valid[r_cmp_idx] && (note_rdata == r_note);
    assign older       = r_cmp_vld && ((r_cmp_idx == '0) || (start_rdata < r_min));
    assign push        = i_cmd.emit_free && (r_depth < NV);
    assign emit        = i_cmd.emit_kill || i_cmd.emit_free || i_cmd.emit_start;
    assign out_free    = !r_out_vld || !i_out_stall;

    always_comb begin
        o_sts.is_on       = (i_in_data.status_byte == pva_pkg::ST_NOTE_ON);
        o_sts.is_off      = (i_in_data.status_byte == pva_pkg::ST_NOTE_OFF);
        o_sts.stack_empty = (r_depth == '0);
        o_sts.scan_done   = r_cmp_vld && (r_cmp_idx == LAST_IDX);
        o_sts.found       = r_found || note_hit;
        o_sts.out_free    = out_free;
    end

    always_comb begin
        n_busy = r_busy;
        if (i_cmd.emit_start) begin
            n_busy = r_busy + CW'(1);
        end else if ((i_cmd.emit_kill || i_cmd.emit_free) && (r_busy != '0)) begin
            n_busy = r_busy - CW'(1);
        end
    end

    always_comb begin
        n_depth = r_depth;
        if (push) begin
            n_depth = r_depth + CW'(1);
        end else if (i_cmd.emit_start && !r_steal) begin
            n_depth = r_depth - CW'(1);
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.command    = pva_pkg::CMD_SILENCE;
        n_out.busy_count = 3'(n_busy);
        if (i_cmd.emit_start) begin
            n_out.command       = pva_pkg::CMD_START;
            n_out.voice_index   = 3'(start_voice);
            n_out.note_out      = r_note;
            n_out.frequency_q8  = pva_pkg::freq_q8(r_note);
            n_out.amplitude_q15 = pva_pkg::amp_q15(r_vel);
            n_out.last          = 1'b1;
        end else if (i_cmd.emit_kill) begin
            n_out.voice_index = 3'(r_old);
        end else begin
            n_out.voice_index = 3'(r_hit);
            n_out.last        = 1'b1;
        end
    end

    pva_ram #(.WIDTH(7), .DEPTH(VOICES)) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.emit_start),
        .i_waddr (start_voice),
        .i_wdata (r_note),
        .i_raddr (r_scan_addr[VW-1:0]),
        .o_rdata (note_rdata)
    );

    pva_ram #(.WIDTH(TIME_BITS), .DEPTH(VOICES)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.emit_start),
        .i_waddr (start_voice),
        .i_wdata (r_time),
        .i_raddr (r_scan_addr[VW-1:0]),
        .o_rdata (start_rdata)
    );

    pva_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_depth[VW-1:0]),
        .i_wdata (r_hit),
        .i_raddr (stk_ridx),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_valid     <= '0;
            r_stk_wr    <= '0;
            r_depth     <= NV;
            r_busy      <= '0;
            r_scan_addr <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_steal     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_time  <= r_time + TIME_BITS'(i_in_data.delta_ticks);
                r_steal <= 1'b0;
            end else if (i_cmd.emit_kill) begin
                r_steal <= 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
                r_cmp_vld   <= 1'b0;
                r_found     <= 1'b0;
            end else begin
                r_scan_addr <= r_scan_addr + CW'(scan_issue);
                r_cmp_vld   <= scan_issue;
                if (note_hit && !r_found) begin
                    r_found <= 1'b1;
                end
            end

            if (i_cmd.emit_start) begin
                r_valid[start_voice] <= 1'b1;
            end else if (i_cmd.emit_kill) begin
                r_valid[r_old] <= 1'b0;
            end else if (i_cmd.emit_free) begin
                r_valid[r_hit] <= 1'b0;
            end

            if (push) begin
                r_stk_wr[r_depth[VW-1:0]] <= 1'b1;
            end

            r_depth <= n_depth;
            r_busy  <= n_busy;

            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_note <= i_in_data.note_number;
            r_vel  <= i_in_data.velocity;
        end
        r_cmp_idx <= r_scan_addr[VW-1:0];
        if (older) begin
            r_min <= start_rdata;
            r_old <= r_cmp_idx;
        end
        if (!i_cmd.scan_start && note_hit && !r_found) begin
            r_hit <= r_cmp_idx;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> src/polyphonic_voice_allocator.sv
// Top level of the polyphonic voice allocator.
// Takes one MIDI event per transaction and answers with voice commands. A note-on
// with a free voice pops it from the free stack and starts it; a note-off scans
// for its note and frees the voice if found; a note-on with no free voice scans for
// the oldest voice, kills it and starts it anew; any other status gives no result.
// Scans read voice note and start times one voice per cycle on a single read port.
// A result waits in an output register, so a stalled result holds back the next
// event only when that event itself has a result to deliver.
module polyphonic_voice_allocator #(
    parameter int VOICES    = 5,
    parameter int TIME_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pva_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pva_pkg::t_out o_out_data
);

    pva_pkg::t_cmd cmd;
    pva_pkg::t_sts sts;

    pva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pva_dp #(
        .VOICES    (VOICES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
